[rtl/mersenne_twister_rng_top_defines.svh]
// ----------------------------------------------------------------------------
// mersenne_twister_rng_top_defines: assertion macros
// Shared concurrent assertion forms for the generator checker. Each expects
// clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_RNG_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_RNG_TOP_DEFINES_SVH

// overlapping implication, checked while out of reset
`define MTR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtr check failed");

// next-cycle implication, checked while out of reset
`define MTR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtr check failed");

`endif

[rtl/mtr_pkg.sv]
// ----------------------------------------------------------------------------
// mtr_pkg: Mersenne Twister generator shared definitions
// Sizes, constants and the command/status/config types that join the
// controller, datapath and register file.
// ----------------------------------------------------------------------------
`default_nettype none

package mtr_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned PADDR_W      = 4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam word_t SEED_MULT  = 32'd1812433253;
	localparam word_t UPPER_BIT  = 32'h8000_0000;
	localparam word_t LOWER_BITS = 32'h7FFF_FFFF;

	// opcode of an input transaction
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// which word the datapath reads from the store
	typedef enum logic [1:0] {
		RSEL_CUR,
		RSEL_NXT,
		RSEL_FAR
	} rsel_t;

	typedef struct packed {
		logic  seed_start;
		logic  seed_step;
		logic  ld_cur;
		logic  ld_nxt;
		logic  twist_we;
		logic  ld_zero;
		logic  out_load;
		logic  pos_clear;
		rsel_t rsel;
	} cmd_t;

	typedef struct packed {
		logic seed_last;
	} status_t;

	typedef struct packed {
		word_t      twist_matrix;
		word_t      temper_mask_b;
		word_t      temper_mask_c;
		logic [3:0] temper_first_shift;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/mtr_ram.sv]
// ----------------------------------------------------------------------------
// mtr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/mtr_regs.sv]
// ----------------------------------------------------------------------------
// mtr_regs: configuration register file
// APB-style write and read of the twist matrix and tempering parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mtr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output mtr_pkg::cfg_t                     cfg
);

	localparam logic [1:0] REG_TWIST   = 2'd0;
	localparam logic [1:0] REG_MASK_B  = 2'd1;
	localparam logic [1:0] REG_MASK_C  = 2'd2;
	localparam logic [1:0] REG_SHIFT   = 2'd3;

	localparam mtr_pkg::word_t RST_TWIST  = 32'h9908_B0DF;
	localparam mtr_pkg::word_t RST_MASK_B = 32'h9D2C_5680;
	localparam mtr_pkg::word_t RST_MASK_C = 32'hEFC6_0000;
	localparam logic [3:0]     RST_SHIFT  = 4'd11;

	logic       wr_en;
	logic [1:0] idx;
	mtr_pkg::cfg_t cfg_q;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[3:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.twist_matrix       <= RST_TWIST;
			cfg_q.temper_mask_b      <= RST_MASK_B;
			cfg_q.temper_mask_c      <= RST_MASK_C;
			cfg_q.temper_first_shift <= RST_SHIFT;
		end else if (wr_en) begin
			case (idx)
				REG_TWIST:  cfg_q.twist_matrix       <= pwdata;
				REG_MASK_B: cfg_q.temper_mask_b      <= pwdata;
				REG_MASK_C: cfg_q.temper_mask_c      <= pwdata;
				REG_SHIFT:  cfg_q.temper_first_shift <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TWIST:  prdata = cfg_q.twist_matrix;
			REG_MASK_B: prdata = cfg_q.temper_mask_b;
			REG_MASK_C: prdata = cfg_q.temper_mask_c;
			REG_SHIFT:  prdata = {28'd0, cfg_q.temper_first_shift};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/mtr_datapath.sv]
// ----------------------------------------------------------------------------
// mtr_datapath: word store, seeding recurrence, twist and tempering
// Executes the controller's commands on the 624-word state store.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mtr_pkg::cmd_t    cmd,
	input  wire mtr_pkg::cfg_t    cfg,
	input  wire mtr_pkg::word_t   seed_value,
	output mtr_pkg::status_t      status,
	output mtr_pkg::word_t        random_word
);

	localparam int unsigned AW = mtr_pkg::ADDR_W;

	mtr_pkg::addr_t pos_q;
	mtr_pkg::addr_t j_q;
	mtr_pkg::word_t prev_q;
	mtr_pkg::word_t cur_q;
	mtr_pkg::word_t nxt_q;
	mtr_pkg::word_t w_q;
	mtr_pkg::word_t out_q;

	mtr_pkg::addr_t pos_inc;
	logic [AW:0]    far_sum;
	mtr_pkg::addr_t far_addr;
	mtr_pkg::addr_t raddr;
	mtr_pkg::addr_t waddr;
	mtr_pkg::word_t wdata;
	mtr_pkg::word_t rdata;
	logic           we;
	mtr_pkg::word_t mixed;
	mtr_pkg::word_t twisted;
	mtr_pkg::word_t seed_mix;
	mtr_pkg::word_t seed_prod;
	mtr_pkg::word_t seed_next;

	function automatic mtr_pkg::word_t temper(mtr_pkg::word_t y_in, mtr_pkg::cfg_t c);
		mtr_pkg::word_t y;
		y = y_in;
		y = y ^ (y >> c.temper_first_shift);
		y = y ^ ((y << 7) & c.temper_mask_b);
		y = y ^ ((y << 15) & c.temper_mask_c);
		y = y ^ (y >> 18);
		return y;
	endfunction

	assign pos_inc = (pos_q == AW'(mtr_pkg::STATE_WORDS - 1)) ? '0 : pos_q + 1'b1;
	assign far_sum = {1'b0, pos_q} + (AW+1)'(mtr_pkg::TWIST_OFFSET);
	assign far_addr = (far_sum >= (AW+1)'(mtr_pkg::STATE_WORDS)) ?
		AW'(far_sum - (AW+1)'(mtr_pkg::STATE_WORDS)) : far_sum[AW-1:0];

	always_comb begin
		case (cmd.rsel)
			mtr_pkg::RSEL_CUR: raddr = pos_q;
			mtr_pkg::RSEL_NXT: raddr = pos_inc;
			mtr_pkg::RSEL_FAR: raddr = far_addr;
			default:           raddr = pos_q;
		endcase
	end

	// rdata holds the far word while the twist command is up
	assign mixed   = (cur_q & mtr_pkg::UPPER_BIT) | (nxt_q & mtr_pkg::LOWER_BITS);
	assign twisted = rdata ^ (mixed >> 1) ^ (nxt_q[0] ? cfg.twist_matrix : '0);

	assign seed_mix  = prev_q ^ (prev_q >> 30);
	assign seed_prod = seed_mix * mtr_pkg::SEED_MULT;
	assign seed_next = seed_prod + {{(mtr_pkg::WORD_W-AW){1'b0}}, j_q} + 1'b1;

	assign we    = cmd.seed_step | cmd.twist_we;
	assign waddr = cmd.seed_step ? j_q : pos_q;
	assign wdata = cmd.seed_step ? prev_q : twisted;

	mtr_ram #(
		.WIDTH(mtr_pkg::WORD_W),
		.DEPTH(mtr_pkg::STATE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			j_q   <= '0;
		end else begin
			if (cmd.pos_clear) begin
				pos_q <= '0;
			end else if (cmd.out_load) begin
				pos_q <= pos_inc;
			end
			if (cmd.seed_start) begin
				j_q <= '0;
			end else if (cmd.seed_step) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_start) begin
			prev_q <= seed_value;
		end else if (cmd.seed_step) begin
			prev_q <= seed_next;
		end
		if (cmd.ld_cur) begin
			cur_q <= rdata;
		end
		if (cmd.ld_nxt) begin
			nxt_q <= rdata;
		end
		if (cmd.twist_we) begin
			w_q <= twisted;
		end else if (cmd.ld_zero) begin
			w_q <= '0;
		end
		if (cmd.out_load) begin
			out_q <= temper(w_q, cfg);
		end
	end

	assign status.seed_last = (j_q == AW'(mtr_pkg::STATE_WORDS - 1));
	assign random_word      = out_q;

endmodule

`default_nettype wire

[rtl/mtr_ctrl.sv]
// ----------------------------------------------------------------------------
// mtr_ctrl: generator controller
// Sequences seeding and the read/twist/temper steps of a draw, and owns the
// input stall and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire logic              opcode,
	output logic                   cmd_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	input  wire mtr_pkg::status_t  status,
	output mtr_pkg::cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_RD_CUR,
		S_RD_NXT,
		S_RD_FAR,
		S_TWIST,
		S_OUT
	} state_t;

	state_t state_q;
	logic   seeded_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   slot_free;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.rsel = mtr_pkg::RSEL_CUR;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.seed_start = (opcode == mtr_pkg::OP_SEED);
					// the store is not read until seeded, so the result is forced to zero
					cmd.ld_zero    = (opcode == mtr_pkg::OP_DRAW) && !seeded_q;
				end
			end
			S_SEED: begin
				cmd.seed_step = 1'b1;
				cmd.pos_clear = status.seed_last;
			end
			S_RD_CUR: cmd.rsel = mtr_pkg::RSEL_CUR;
			S_RD_NXT: begin
				cmd.rsel   = mtr_pkg::RSEL_NXT;
				cmd.ld_cur = 1'b1;
			end
			S_RD_FAR: begin
				cmd.rsel   = mtr_pkg::RSEL_FAR;
				cmd.ld_nxt = 1'b1;
			end
			S_TWIST: cmd.twist_we = 1'b1;
			S_OUT:   cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= cmd.out_load | (rsp_valid_q & rsp_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == mtr_pkg::OP_SEED) begin
							state_q <= S_SEED;
						end else if (seeded_q) begin
							state_q <= S_RD_CUR;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SEED: begin
					if (status.seed_last) begin
						state_q  <= S_IDLE;
						seeded_q <= 1'b1;
					end
				end
				S_RD_CUR: state_q <= S_RD_NXT;
				S_RD_NXT: state_q <= S_RD_FAR;
				S_RD_FAR: state_q <= S_TWIST;
				S_TWIST:  state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/mersenne_twister_rng_top.sv]
// ----------------------------------------------------------------------------
// mersenne_twister_rng_top: configurable MT19937-family generator
// 624-word Mersenne Twister with per-draw twisting and APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall, opcode, seed_value): opcode 0 seeds the
//   generator, opcode 1 draws one word. rsp channel (rsp_valid/rsp_stall,
//   random_word) returns one tempered word per draw; a seed returns nothing.
//   A seed steps the 1812433253 recurrence one word per cycle through the
//   store, holding cmd_stall high until the whole store is written.
//   A draw reads three store words through the single read port of the RAM
//   (current, next, far), twists and writes back, then tempers into the
//   output register; a new item is taken only once the draw has finished.
//   Draws before any seed skip the store and temper a zero word; a new item
//   is likewise taken only once the draw has finished.
//   A finished result sits in the output register while the next item is
//   accepted; if rsp_stall holds it, the following draw waits in its last
//   step until the register frees. Reset restores the default parameter set
//   and marks the store unseeded; no clearing pass is needed. The user must
//   write configuration registers only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_rng_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mtr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        cmd_valid,
	output logic                             cmd_stall,
	input  wire logic                        opcode,
	input  wire logic [31:0]                 seed_value,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic      [31:0]                 random_word
);

	mtr_pkg::cfg_t    cfg;
	mtr_pkg::cmd_t    cmd;
	mtr_pkg::status_t status;

	assign pready = 1'b1;

	mtr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	mtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.opcode   (opcode),
		.cmd_stall(cmd_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mtr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.seed_value (seed_value),
		.status     (status),
		.random_word(random_word)
	);

endmodule

`default_nettype wire

[rtl/mtr_checker.sv]
// ----------------------------------------------------------------------------
// mtr_checker: port-level checks for the generator
// Watches the top level's channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mersenne_twister_rng_top_defines.svh"

module mtr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_stall,
	input wire logic        opcode,
	input wire logic        rsp_valid,
	input wire logic        rsp_stall,
	input wire logic [31:0] random_word
);

	logic cmd_acc;
	logic seed_acc;

	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign seed_acc = cmd_acc && (opcode == mtr_pkg::OP_SEED);

	// a held result stays put
	`MTR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(random_word))

	// every accepted transaction raises the stall in the following cycle
	`MTR_ASSERT_NXT(a_busy_after_accept, cmd_acc, cmd_stall)

	// seeding makes no result
	`MTR_ASSERT_NXT(a_seed_silent, seed_acc && !rsp_valid, !rsp_valid)

	// seeding walks the whole store, one word per cycle
	`MTR_ASSERT_IMP(a_seed_length, seed_acc, ##624 cmd_stall ##1 !cmd_stall)

endmodule

bind mersenne_twister_rng_top mtr_checker u_chk (.*);

`default_nettype wire
